>>> sv/ptt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the pid timestamp table with report filter.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PID_W     = 22;
  localparam int STAMP_W   = 64;
  localparam int GAP_W     = 10;
  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(10);
  localparam logic [GAP_W-1:0] GAP_LIMIT = GAP_W'(1000);

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_QUERY  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FILTERED  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [PID_W-1:0]   pid;
    logic [STAMP_W-1:0] stamp;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [STAMP_W-1:0] last_stamp;
  } rsp_t;

  // Request walking the cell row
  typedef struct packed {
    logic               active;
    func_t              func;
    logic [PID_W-1:0]   pid;
    logic [STAMP_W-1:0] stamp;
    logic               found;
    logic [STAMP_W-1:0] hit_time;
    logic               free_seen;
    logic [IDX_W-1:0]   free_idx;
  } token_t;

  // Slot claim broadcast from the tail of the row
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [PID_W-1:0]   pid;
    logic [STAMP_W-1:0] stamp;
  } claim_t;

endpackage

>>> sv/pid_timestamp_table_with_rate_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_timestamp_table_with_rate_filter_core
// Pid to timestamp table with a repeat-report filter, built as a row of slots
// that a request walks one slot per cycle.
//
//   channel   ports                      direction  handshake
//   request   start, busy, req           in         start && !busy
//   result    done, rsp                  out        done, one cycle, no stall
//   config    cfg_valid, cfg_ready,      in         cfg_valid && cfg_ready
//             cfg_data
//
// Add, remove and query are registered at launch and walk all ENTRIES slots
// in turn; done rises as busy falls, so the next request may start then.
// A filtered add and a clear finish at once: done in the next cycle, and a
// new request may be taken in that cycle.
// Reset clears every slot at once; the gap register returns to 10.
// The result side cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
module pid_timestamp_table_with_rate_filter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ptt_pkg::req_t                 req,
  output logic                          done,
  output ptt_pkg::rsp_t                 rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptt_pkg::GAP_W-1:0]     cfg_data
);

  logic [ptt_pkg::GAP_W-1:0]    min_gap;
  logic [ptt_pkg::PID_W-1:0]    last_pid;
  logic [ptt_pkg::STAMP_W-1:0]  last_time;
  logic [ptt_pkg::STAMP_W-1:0]  delta;
  logic                         accept;
  logic                         is_add;
  logic                         is_clear;
  logic                         pass;
  logic                         walk;
  ptt_pkg::token_t              launch;
  ptt_pkg::token_t              row [ptt_pkg::ENTRIES+1];
  ptt_pkg::token_t              tail;
  ptt_pkg::claim_t              claim;
  ptt_pkg::rsp_t                rsp_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= ptt_pkg::GAP_RESET;
    end else if (cfg_valid && cfg_ready && cfg_data < ptt_pkg::GAP_LIMIT) begin
      min_gap <= cfg_data;
    end
  end

  assign accept   = start && !busy;
  assign is_add   = (req.func == ptt_pkg::FN_ADD);
  assign is_clear = (req.func == ptt_pkg::FN_CLEAR);
  assign delta    = req.stamp - last_time;
  assign pass     = (req.pid != last_pid) ||
                    ((req.stamp > last_time) &&
                     (delta >= {{(ptt_pkg::STAMP_W-ptt_pkg::GAP_W){1'b0}}, min_gap}));
  assign walk     = accept && !is_clear && (!is_add || pass);

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pid  <= '0;
      last_time <= '0;
    end else if (accept && is_add && pass) begin
      last_pid  <= req.pid;
      last_time <= req.stamp;
    end
  end

  always_ff @(posedge clk) begin
    launch.func      <= req.func;
    launch.pid       <= req.pid;
    launch.stamp     <= req.stamp;
    launch.found     <= 1'b0;
    launch.hit_time  <= '0;
    launch.free_seen <= 1'b0;
    launch.free_idx  <= '0;
    if (rst) begin
      launch.active <= 1'b0;
    end else begin
      launch.active <= walk;
    end
  end

  assign row[0] = launch;
  assign tail   = row[ptt_pkg::ENTRIES];

  for (genvar i = 0; i < ptt_pkg::ENTRIES; i++) begin : g_cell
    ptt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (ptt_pkg::IDX_W'(i)),
      .tok_in  (row[i]),
      .tok_out (row[i+1]),
      .claim   (claim),
      .clr     (accept && is_clear)
    );
  end

  always_comb begin
    claim.en    = tail.active && (tail.func == ptt_pkg::FN_ADD) &&
                  !tail.found && tail.free_seen;
    claim.idx   = tail.free_idx;
    claim.pid   = tail.pid;
    claim.stamp = tail.stamp;
  end

  always_comb begin
    rsp_next.status     = ptt_pkg::ST_DONE;
    rsp_next.last_stamp = '0;
    if (tail.active) begin
      if (tail.func == ptt_pkg::FN_ADD) begin
        if (!tail.found && !tail.free_seen) begin
          rsp_next.status = ptt_pkg::ST_FULL;
        end
      end else if (!tail.found) begin
        rsp_next.status = ptt_pkg::ST_NOT_FOUND;
      end else if (tail.func == ptt_pkg::FN_QUERY) begin
        rsp_next.last_stamp = tail.hit_time;
      end
    end else if (is_add) begin
      rsp_next.status = ptt_pkg::ST_FILTERED;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= tail.active || (accept && !walk);
      if (walk) begin
        busy <= 1'b1;
      end else if (tail.active) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> sv/ptt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_cell
// One table slot: holds a key and time, matches the passing request and hands
// it on to the next slot through a register, so that slot sees it in the next cycle.
// ----------------------------------------------------------------------------
module ptt_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ptt_pkg::IDX_W-1:0]  idx,
  input  ptt_pkg::token_t            tok_in,
  output ptt_pkg::token_t            tok_out,
  input  ptt_pkg::claim_t            claim,
  input  logic                       clr
);

  logic                         valid;
  logic [ptt_pkg::PID_W-1:0]    key;
  logic [ptt_pkg::STAMP_W-1:0]  time_q;
  ptt_pkg::token_t              tok_next;
  logic                         hit;
  logic                         claimed;

  assign hit     = tok_in.active && valid && (key == tok_in.pid) && !tok_in.found;
  assign claimed = claim.en && (claim.idx == idx);

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.found = 1'b1;
      if (tok_in.func == ptt_pkg::FN_QUERY) begin
        tok_next.hit_time = time_q;
      end
    end
    if (tok_in.active && !valid && !tok_in.free_seen) begin
      tok_next.free_seen = 1'b1;
      tok_next.free_idx  = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (clr) begin
      valid <= 1'b0;
    end else if (hit && tok_in.func == ptt_pkg::FN_REMOVE) begin
      valid <= 1'b0;
    end else if (claimed) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (claimed) begin
      key    <= claim.pid;
      time_q <= claim.stamp;
    end else if (hit && tok_in.func == ptt_pkg::FN_ADD) begin
      time_q <= tok_in.stamp;
    end
  end

endmodule
